// ===== rtl/gbps_pkg.sv =====
// Package for the glyph bitmap to pixel stream unit.
// Holds field widths, register indexes, reset values and the beat types.
// No dependencies.
`default_nettype none

package gbps_pkg;

  // Fixed field widths.
  localparam int unsigned WidthW   = 6;
  localparam int unsigned HeightW  = 7;
  localparam int unsigned ColorW   = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned BitIdxW  = 3;
  localparam int unsigned NpixW    = 4;
  localparam int unsigned RowW     = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Tallest glyph the row counter supports.
  localparam int unsigned MaxHeight = 64;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] CfgGlyphWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGlyphHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgFgColor     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgBgColor     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDoubleHt    = 3'd4;

  // Register reset values.
  localparam logic [WidthW-1:0]  RstGlyphWidth  = 6'd8;
  localparam logic [HeightW-1:0] RstGlyphHeight = 7'd16;
  localparam logic [ColorW-1:0]  RstFgColor     = 16'hFFFF;
  localparam logic [ColorW-1:0]  RstBgColor     = 16'h0000;

  typedef struct packed {
    logic [WidthW-1:0]  glyph_width;
    logic [HeightW-1:0] glyph_height;
    logic [ColorW-1:0]  fg_color;
    logic [ColorW-1:0]  bg_color;
    logic               double_height;
  } cfg_t;

  // One classified bitmap byte, handed from the front to the back.
  typedef struct packed {
    logic [ByteW-1:0]  glyph_byte;
    logic [WidthW-1:0] start;      // first pixel column of this byte
    logic [NpixW-1:0]  npix;       // used bits in this byte, 0 to 8
    logic [WidthW-1:0] width;      // effective row width for the repeat pass
    logic              rep_row;    // replay the row after this byte
    logic              glyph_end;  // this byte closes the glyph
  } cmd_t;

  // One output pixel beat.
  typedef struct packed {
    logic [ColorW-1:0] color;
    logic              is_repeat;
    logic              last;
  } pix_t;

  localparam int unsigned CmdW = $bits(cmd_t);
  localparam int unsigned PixW = $bits(pix_t);

endpackage

`default_nettype wire

// ===== rtl/gbps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gbps_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gbps_fifo.sv =====
// Small register FIFO used for the command queue and the pixel queue.
// DEPTH must be a power of two, at least two. No dependencies.
`default_nettype none

module gbps_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       pop_i,
  output logic      [WIDTH-1:0]           rdata_o,
  output logic      [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  // Pointer and fill count update; callers never push when full or pop when empty.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

`default_nettype wire

// ===== rtl/gbps_front.sv =====
// Front end: accepts bitmap bytes, tracks row and byte position, and
// classifies each byte into a command for the back end. Uses gbps_pkg.
`default_nettype none

module gbps_front
  import gbps_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 48
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             push_i,
  input  wire logic [ByteW-1:0] glyph_byte_i,
  input  wire logic             cmd_full_i,
  output logic                  cmd_push_o,
  output cmd_t                  cmd_o
);

  logic [RowW-1:0]    row_q, row_d;
  logic [BitIdxW-1:0] byte_q, byte_d;

  logic               accept;
  logic [WidthW-1:0]  width;
  logic [HeightW-1:0] height;
  logic [HeightW-1:0] width_sum;
  logic [NpixW-1:0]   bytes_per_row;
  logic [WidthW-1:0]  start;
  logic [WidthW-1:0]  remain;
  logic [NpixW-1:0]   npix;
  logic               row_end;
  logic               glyph_end;

  assign accept = push_i && !cmd_full_i;

  // Clamp the geometry registers to the supported range.
  always_comb begin
    if (cfg_i.glyph_width == '0) begin
      width = WidthW'(1);
    end else if (cfg_i.glyph_width > WidthW'(MAX_WIDTH)) begin
      width = WidthW'(MAX_WIDTH);
    end else begin
      width = cfg_i.glyph_width;
    end
    if (cfg_i.glyph_height == '0) begin
      height = HeightW'(1);
    end else if (cfg_i.glyph_height > HeightW'(MaxHeight)) begin
      height = HeightW'(MaxHeight);
    end else begin
      height = cfg_i.glyph_height;
    end
  end

  // Classify the byte at the current position.
  always_comb begin
    width_sum     = {1'b0, width} + HeightW'(ByteW - 1);
    bytes_per_row = width_sum[HeightW-1:BitIdxW];
    start         = {byte_q, BitIdxW'(0)};
    remain        = (width > start) ? (width - start) : '0;
    npix          = (remain >= WidthW'(ByteW)) ? NpixW'(ByteW) : remain[NpixW-1:0];
    row_end       = ({1'b0, byte_q} + NpixW'(1)) >= bytes_per_row;
    glyph_end     = row_end && (({1'b0, row_q} + HeightW'(1)) >= height);
  end

  always_comb begin
    cmd_o.glyph_byte = glyph_byte_i;
    cmd_o.start      = start;
    cmd_o.npix       = npix;
    cmd_o.width      = width;
    cmd_o.rep_row    = row_end && cfg_i.double_height;
    cmd_o.glyph_end  = glyph_end;
  end

  assign cmd_push_o = accept;

  // Position counters advance with each accepted byte.
  always_comb begin
    row_d  = row_q;
    byte_d = byte_q;
    if (accept) begin
      if (!row_end) begin
        byte_d = byte_q + BitIdxW'(1);
      end else begin
        byte_d = '0;
        row_d  = glyph_end ? '0 : row_q + RowW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      byte_q <= '0;
    end else begin
      row_q  <= row_d;
      byte_q <= byte_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gbps_back.sv =====
// Back end: expands commands into pixels, one per cycle unless stalled,
// keeps the row in a line store, replays it. Uses gbps_pkg, gbps_ram.
`default_nettype none

module gbps_back
  import gbps_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 48,
  parameter int unsigned OUT_DEPTH = 4
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire cfg_t                           cfg_i,
  input  wire cmd_t                           cmd_i,
  input  wire logic                           cmd_empty_i,
  output logic                                cmd_pop_o,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count_i,
  output logic                                out_push_o,
  output pix_t                                out_pix_o
);

  localparam int unsigned AddrW   = $clog2(MAX_WIDTH);
  localparam int unsigned OutCntW = $clog2(OUT_DEPTH + 1);
  localparam int unsigned OccW    = OutCntW + 1;

  typedef enum logic [1:0] {
    StIdle,
    StByte,
    StRep
  } state_e;

  state_e             state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic [BitIdxW-1:0] k_q, k_d;
  logic [WidthW-1:0]  j_q, j_d;
  logic               pix_valid_q, pix_valid_d;
  logic               pix_ram_q, pix_ram_d;
  logic               pix_bit_q, pix_bit_d;
  logic               pix_rep_q, pix_rep_d;
  logic               pix_last_q, pix_last_d;

  logic              credit;
  logic              load;
  logic              byte_done;
  logic              last_k;
  logic              last_j;
  logic              ram_we;
  logic              ram_re;
  logic [WidthW-1:0] waddr_full;
  logic              ram_rdata;
  logic              cur_bit;

  // Issue only while the pixel queue has room for the beat in flight too.
  assign credit = ({1'b0, out_count_i} + OccW'(pix_valid_q)) < OccW'(OUT_DEPTH);

  assign last_k     = ({1'b0, k_q} == (cmd_q.npix - NpixW'(1)));
  assign last_j     = (j_q == (cmd_q.width - WidthW'(1)));
  assign waddr_full = cmd_q.start + WidthW'(k_q);
  assign cur_bit    = cmd_q.glyph_byte[BitIdxW'(ByteW - 1) - k_q];

  // Sequencer: byte pixels, then the optional replay of the whole row.
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    k_d         = k_q;
    j_d         = j_q;
    pix_valid_d = 1'b0;
    pix_ram_d   = 1'b0;
    pix_bit_d   = pix_bit_q;
    pix_rep_d   = pix_rep_q;
    pix_last_d  = pix_last_q;
    load        = 1'b0;
    byte_done   = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    unique case (state_q)
      StIdle: begin
        load = !cmd_empty_i;
      end
      StByte: begin
        if (cmd_q.npix == '0) begin
          byte_done = 1'b1;
        end else if (credit) begin
          ram_we      = 1'b1;
          pix_valid_d = 1'b1;
          pix_bit_d   = cur_bit;
          pix_rep_d   = 1'b0;
          pix_last_d  = cmd_q.glyph_end && !cmd_q.rep_row && last_k;
          k_d         = k_q + BitIdxW'(1);
          byte_done   = last_k;
        end
        if (byte_done) begin
          if (cmd_q.rep_row) begin
            state_d = StRep;
            j_d     = '0;
          end else begin
            load    = !cmd_empty_i;
            state_d = StIdle;
          end
        end
      end
      StRep: begin
        if (credit) begin
          ram_re      = 1'b1;
          pix_valid_d = 1'b1;
          pix_ram_d   = 1'b1;
          pix_rep_d   = 1'b1;
          pix_last_d  = cmd_q.glyph_end && last_j;
          j_d         = j_q + WidthW'(1);
          if (last_j) begin
            load    = !cmd_empty_i;
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    if (load) begin
      cmd_d   = cmd_i;
      k_d     = '0;
      state_d = StByte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cmd_q       <= '0;
      k_q         <= '0;
      j_q         <= '0;
      pix_valid_q <= 1'b0;
      pix_ram_q   <= 1'b0;
      pix_bit_q   <= 1'b0;
      pix_rep_q   <= 1'b0;
      pix_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      k_q         <= k_d;
      j_q         <= j_d;
      pix_valid_q <= pix_valid_d;
      pix_ram_q   <= pix_ram_d;
      pix_bit_q   <= pix_bit_d;
      pix_rep_q   <= pix_rep_d;
      pix_last_q  <= pix_last_d;
    end
  end

  assign cmd_pop_o = load;

  // Line store of the current row, one bit per column.
  gbps_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr_full[AddrW-1:0]),
    .wdata_i (cur_bit),
    .re_i    (ram_re),
    .raddr_i (j_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Color lookup on the staged beat.
  always_comb begin
    out_pix_o.color     = (pix_ram_q ? ram_rdata : pix_bit_q) ? cfg_i.fg_color
                                                              : cfg_i.bg_color;
    out_pix_o.is_repeat = pix_rep_q;
    out_pix_o.last      = pix_last_q;
  end

  assign out_push_o = pix_valid_q;

endmodule

`default_nettype wire

// ===== rtl/glyph_bitmap_to_pixel_stream_unit.sv =====
// Glyph bitmap to pixel stream unit, top level.
// Holds the configuration registers and joins front, command queue, back
// and pixel queue. Uses gbps_pkg, gbps_front, gbps_back and gbps_fifo.
// Usage:
//   Input channel: a bitmap byte beat is taken on a rising edge with push_i
//   high and full_o low. Rows are padded to whole bytes, MSB leftmost.
//   Output channel: while empty_o is low the oldest pixel beat sits on
//   pixel_color_o, is_repeat_o and last_pixel_o; pop_i takes it.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 width, 1 height, 2 foreground, 3 background, 4 double height);
//   write only while the unit is idle.
// Timing:
//   The first pixel of a byte passes the command queue, then the back end's
//   command register and staged beat register, then enters the pixel queue.
//   The back end issues one pixel per cycle while the pixel queue has room;
//   a row replay issues one per column; a byte with no used bits, none.
//   A two-entry command queue lets bytes be taken while the back end works.
// Reset clears both queues and the row and byte counters and restores the
// register defaults. When the receiver stalls, the pixel queue fills and the
// back end holds, then the command queue fills and full_o rises.
`default_nettype none

module glyph_bitmap_to_pixel_stream_unit
  import gbps_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 48
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  output logic                     full_o,
  input  wire logic [ByteW-1:0]    glyph_byte_i,
  output logic                     empty_o,
  input  wire logic                pop_i,
  output logic      [ColorW-1:0]   pixel_color_o,
  output logic                     is_repeat_o,
  output logic                     last_pixel_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CmdDepth = 2;
  localparam int unsigned OutDepth = 4;
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

  cfg_t               cfg_q;
  logic               cmd_push;
  cmd_t               cmd_in;
  cmd_t               cmd_out;
  logic               cmd_pop;
  logic [CmdCntW-1:0] cmd_count;
  logic               cmd_empty;
  logic               out_push;
  pix_t               out_pix;
  pix_t               out_head;
  logic               out_pop;
  logic [OutCntW-1:0] out_count;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glyph_width   <= RstGlyphWidth;
      cfg_q.glyph_height  <= RstGlyphHeight;
      cfg_q.fg_color      <= RstFgColor;
      cfg_q.bg_color      <= RstBgColor;
      cfg_q.double_height <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgGlyphWidth:  cfg_q.glyph_width   <= cfg_data_i[WidthW-1:0];
        CfgGlyphHeight: cfg_q.glyph_height  <= cfg_data_i[HeightW-1:0];
        CfgFgColor:     cfg_q.fg_color      <= cfg_data_i[ColorW-1:0];
        CfgBgColor:     cfg_q.bg_color      <= cfg_data_i[ColorW-1:0];
        CfgDoubleHt:    cfg_q.double_height <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign full_o    = (cmd_count == CmdCntW'(CmdDepth));
  assign cmd_empty = (cmd_count == '0);

  gbps_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .push_i       (push_i),
    .glyph_byte_i (glyph_byte_i),
    .cmd_full_i   (full_o),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  gbps_fifo #(
    .WIDTH (CmdW),
    .DEPTH (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .count_o (cmd_count)
  );

  gbps_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .OUT_DEPTH (OutDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .out_count_i (out_count),
    .out_push_o  (out_push),
    .out_pix_o   (out_pix)
  );

  gbps_fifo #(
    .WIDTH (PixW),
    .DEPTH (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_pix),
    .pop_i   (out_pop),
    .rdata_o (out_head),
    .count_o (out_count)
  );

  assign empty_o       = (out_count == '0);
  assign out_pop       = pop_i && !empty_o;
  assign pixel_color_o = out_head.color;
  assign is_repeat_o   = out_head.is_repeat;
  assign last_pixel_o  = out_head.last;

endmodule

`default_nettype wire

// ===== rtl/gbps_checker.sv =====
// Port-level checker for the glyph bitmap to pixel stream unit, with the
// bind that attaches it to the top level. Depends on the top level only.
`default_nettype none

module gbps_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        push_i,
  input wire logic        full_o,
  input wire logic        empty_o,
  input wire logic        pop_i,
  input wire logic [15:0] pixel_color_o,
  input wire logic        is_repeat_o,
  input wire logic        last_pixel_o
);

  logic seen_q;

  // Remembers whether any bitmap byte has been taken since reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (push_i && !full_o) begin
      seen_q <= 1'b1;
    end
  end

  // Out of reset the pixel queue is empty and the command queue not full.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty_o && !full_o)
    else $error("queues not empty after reset");

  // No pixel beat appears before any byte has been taken.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> seen_q)
    else $error("pixel beat without any input byte");

  // The command queue only fills through an accepted byte.
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full_o) |-> $past(push_i && !full_o))
    else $error("full raised without an accepted byte");

  // A waiting pixel beat holds while the receiver stalls.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(pixel_color_o) &&
                           $stable(is_repeat_o) && $stable(last_pixel_o))
    else $error("stalled pixel beat changed");

endmodule

bind glyph_bitmap_to_pixel_stream_unit gbps_checker u_checker (.*);

`default_nettype wire

// ===== tb/glyph_bitmap_to_pixel_stream_unit_tb.sv =====
// Testbench for the glyph bitmap to pixel stream unit.
// Drives bitmap bytes and register writes, predicts every pixel beat in a scoreboard
// class and checks the pixel queue. Depends on gbps_pkg and the unit's RTL.
`default_nettype none

module glyph_bitmap_to_pixel_stream_unit_tb;
  import gbps_pkg::*;

  localparam int unsigned LineMax      = 48;
  localparam int unsigned SettleCycles = 32;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned RandomItems  = 224;
  localparam int unsigned ReportLimit  = 10;

  // Scoreboard: mirrors the registers, the row counters and the line store, and
  // keeps the pixel beats still owed by the unit in arrival order.
  class pixel_scoreboard;
    logic [WidthW-1:0]  width_reg;
    logic [HeightW-1:0] height_reg;
    logic [ColorW-1:0]  fg;
    logic [ColorW-1:0]  bg;
    logic               dbl;
    int unsigned        row_idx;
    int unsigned        byte_pos;
    bit                 line_bits [LineMax];
    pix_t               pixels_due [$];
    int unsigned        errors;
    int unsigned        pixels_checked;
    int unsigned        repeats_checked;
    int unsigned        glyphs_closed;

    function new();
      width_reg       = RstGlyphWidth;
      height_reg      = RstGlyphHeight;
      fg              = RstFgColor;
      bg              = RstBgColor;
      dbl             = 1'b0;
      row_idx         = 0;
      byte_pos        = 0;
      errors          = 0;
      pixels_checked  = 0;
      repeats_checked = 0;
      glyphs_closed   = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgGlyphWidth:  width_reg  = data[WidthW-1:0];
        CfgGlyphHeight: height_reg = data[HeightW-1:0];
        CfgFgColor:     fg         = data[ColorW-1:0];
        CfgBgColor:     bg         = data[ColorW-1:0];
        CfgDoubleHt:    dbl        = data[0];
        default: ;
      endcase
    endfunction

    // Zero acts as one; anything past the line store or row counter is clamped.
    function int unsigned used_width();
      if (width_reg == 0) return 1;
      if (width_reg > LineMax) return LineMax;
      return width_reg;
    endfunction

    function int unsigned used_height();
      if (height_reg == 0) return 1;
      if (height_reg > MaxHeight) return MaxHeight;
      return height_reg;
    endfunction

    function int unsigned row_bytes();
      return (used_width() + 7) / 8;
    endfunction

    // Number of bytes still needed to close the glyph under the current settings.
    function int unsigned bytes_to_glyph_end();
      int unsigned r;
      int unsigned p;
      int unsigned n;
      r = row_idx;
      p = byte_pos;
      n = 0;
      while (n < 1000) begin
        n++;
        if (p + 1 >= row_bytes()) begin
          if (r + 1 >= used_height()) return n;
          r++;
          p = 0;
        end else begin
          p++;
        end
      end
      return n;
    endfunction

    // Expand one accepted bitmap byte into the pixels it is due to produce.
    function void note_byte(logic [ByteW-1:0] b);
      int unsigned w;
      int unsigned first;
      int unsigned col0;
      int unsigned col_end;
      int unsigned col;
      bit          bit_v;
      bit          row_end;
      bit          glyph_end;
      pix_t        p;
      pix_t        tail;
      w       = used_width();
      first   = pixels_due.size();
      col0    = byte_pos * 8;
      col_end = (col0 + 8 > w) ? w : col0 + 8;
      for (col = col0; col < col_end; col++) begin
        bit_v           = b[7 - (col - col0)];
        line_bits[col]  = bit_v;
        p.color         = bit_v ? fg : bg;
        p.is_repeat     = 1'b0;
        p.last          = 1'b0;
        pixels_due.push_back(p);
      end
      row_end   = (byte_pos + 1 >= row_bytes());
      glyph_end = row_end && (row_idx + 1 >= used_height());
      // The finished row is replayed from the line store.
      if (row_end && dbl) begin
        for (col = 0; col < w; col++) begin
          p.color     = line_bits[col] ? fg : bg;
          p.is_repeat = 1'b1;
          p.last      = 1'b0;
          pixels_due.push_back(p);
        end
      end
      // A glyph closed by a byte without pixels flags nothing.
      if (glyph_end) begin
        glyphs_closed++;
        if (pixels_due.size() > first) begin
          tail      = pixels_due.pop_back();
          tail.last = 1'b1;
          pixels_due.push_back(tail);
        end
      end
      if (!row_end) begin
        byte_pos = (byte_pos + 1) & 7;
      end else begin
        byte_pos = 0;
        row_idx  = glyph_end ? 0 : ((row_idx + 1) & 63);
      end
    endfunction

    function void check_pixel(logic [ColorW-1:0] color, logic rep, logic last);
      pix_t want;
      if (pixels_due.size() == 0) begin
        errors++;
        if (errors <= ReportLimit)
          $display("ERROR: pixel color %h rep %b last %b arrived with none expected",
                   color, rep, last);
        return;
      end
      want = pixels_due.pop_front();
      pixels_checked++;
      if (want.is_repeat) repeats_checked++;
      if (want.color !== color || want.is_repeat !== rep || want.last !== last) begin
        errors++;
        if (errors <= ReportLimit) begin
          $display("ERROR: pixel %0d: expected color %h rep %b last %b",
                   pixels_checked, want.color, want.is_repeat, want.last);
          $display("       got color %h rep %b last %b", color, rep, last);
        end
      end
    endfunction
  endclass

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                push_i       = 1'b0;
  logic [ByteW-1:0]    glyph_byte_i = '0;
  logic                pop_i        = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i    = CfgGlyphWidth;
  logic [CfgDataW-1:0] cfg_data_i   = '0;
  logic                full_o;
  logic                empty_o;
  logic [ColorW-1:0]   pixel_color_o;
  logic                is_repeat_o;
  logic                last_pixel_o;

  pixel_scoreboard sb = new();
  int unsigned     bytes_sent  = 0;
  int unsigned     phases_run  = 0;
  int unsigned     full_stalls = 0;
  int unsigned     pops        = 0;
  bit              hold_armed  = 1'b0;
  bit              send_quiet  = 1'b0;
  bit              recv_quiet  = 1'b0;

  glyph_bitmap_to_pixel_stream_unit #(
    .MAX_WIDTH(LineMax)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .glyph_byte_i (glyph_byte_i),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .pixel_color_o(pixel_color_o),
    .is_repeat_o  (is_repeat_o),
    .last_pixel_o (last_pixel_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Idle cycles before a beat; every 32 beats a side may switch to a quiet stretch.
  function automatic int unsigned draw_gap(inout bit quiet, input int unsigned beats);
    if (beats % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
    if (quiet) return 0;
    return $urandom_range(0, 16);
  endfunction

  // Register values, weighted toward small glyphs with the extremes mixed in.
  function automatic logic [CfgDataW-1:0] pick_value(logic [CfgIdxW-1:0] idx);
    int unsigned r;
    r = $urandom_range(0, 19);
    case (idx)
      CfgGlyphWidth: begin
        if (r == 0) return 16'd0;
        if (r == 1) return 16'd48;
        if (r == 2) return 16'($urandom_range(49, 63));
        if (r <= 4) return 16'($urandom_range(17, 47));
        if (r == 5) return 16'd1;
        return 16'($urandom_range(2, 16));
      end
      CfgGlyphHeight: begin
        if (r == 0) return 16'd0;
        if (r == 1) return 16'd64;
        if (r == 2) return 16'($urandom_range(65, 127));
        if (r == 3) return 16'd1;
        return 16'($urandom_range(1, 4));
      end
      CfgFgColor, CfgBgColor: begin
        if (r < 2) return 16'h0000;
        if (r < 4) return 16'hFFFF;
        return 16'($urandom);
      end
      default: return 16'($urandom_range(0, 1));
    endcase
  endfunction

  // Register writes start and end at a falling edge.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.set_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic end_writes();
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_all(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h,
                         input logic [CfgDataW-1:0] fgc, input logic [CfgDataW-1:0] bgc,
                         input logic [CfgDataW-1:0] dbl);
    write_reg(CfgGlyphWidth, w);
    write_reg(CfgGlyphHeight, h);
    write_reg(CfgFgColor, fgc);
    write_reg(CfgBgColor, bgc);
    write_reg(CfgDoubleHt, dbl);
    end_writes();
  endtask

  // Offer one bitmap byte and hold it until the unit takes it.
  task automatic push_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = draw_gap(send_quiet, bytes_sent);
    if (gap != 0) begin
      push_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push_i       <= 1'b1;
    glyph_byte_i <= b;
    do begin
      @(posedge clk_i);
      if (full_o) full_stalls++;
    end while (full_o);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    logic [ByteW-1:0] b;
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else b = 8'($urandom_range(0, 255));
      push_byte(b);
    end
  endtask

  // Wait for every owed pixel, then let bytes without pixels leave the unit.
  task automatic settle();
    push_i <= 1'b0;
    while (sb.pixels_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    phases_run++;
  endtask

  // Pixel receiver with random stalls and one long hold-off on request.
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = draw_gap(recv_quiet, pops);
      if (hold_armed) begin
        gap        = HoldCycles;
        hold_armed = 1'b0;
      end
      if (gap != 0) begin
        pop_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop_i <= 1'b1;
      do @(posedge clk_i); while (empty_o);
      sb.check_pixel(pixel_color_o, is_repeat_o, last_pixel_o);
      pops++;
      @(negedge clk_i);
    end
  end

  // Stimulus: directed corner cases, then random phases with register changes between them.
  initial begin
    logic [ByteW-1:0] seq [$];
    int unsigned      random_sent;
    int unsigned      count;
    int unsigned      left;
    int unsigned      glyph;
    int unsigned      k;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // A full-width row first, so every line store entry is written before any
    // later width change can make a replay read it.
    set_all(16'd48, 16'd1, 16'hF800, 16'h001F, 16'd1);
    seq = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80, 8'h01};
    foreach (seq[i]) push_byte(seq[i]);
    settle();

    // One-pixel glyphs.
    set_all(16'd1, 16'd1, 16'hFFFF, 16'h0000, 16'd0);
    seq = '{8'h80, 8'h7F};
    foreach (seq[i]) push_byte(seq[i]);
    settle();

    // Padded rows with replay; the last byte starts the next glyph.
    set_all(16'd9, 16'd2, 16'h07E0, 16'hFFFF, 16'd1);
    seq = '{8'hC0, 8'h80, 8'hFF, 8'h00, 8'h5A};
    foreach (seq[i]) push_byte(seq[i]);
    settle();

    // The row narrows under a byte in flight: it yields no pixel and closes the glyph.
    write_reg(CfgGlyphWidth, 16'd8);
    write_reg(CfgGlyphHeight, 16'd1);
    write_reg(CfgDoubleHt, 16'd0);
    end_writes();
    push_byte(8'hFF);
    settle();

    // Width and height of zero behave as one.
    write_reg(CfgGlyphWidth, 16'd0);
    write_reg(CfgGlyphHeight, 16'd0);
    end_writes();
    push_byte(8'h80);
    settle();

    // Oversized width and height are clamped to the maxima.
    write_reg(CfgGlyphWidth, 16'd63);
    write_reg(CfgGlyphHeight, 16'd100);
    end_writes();
    send_random(7);
    settle();

    // Height drops below the current row, so this row ends the glyph.
    write_reg(CfgGlyphHeight, 16'd1);
    write_reg(CfgFgColor, 16'h0000);
    end_writes();
    send_random(5);
    settle();

    random_sent = 0;
    k = 0;
    while (random_sent < RandomItems) begin
      if (k == 0) begin
        // Several glyphs while the receiver holds off, so the input stalls.
        set_all(16'd16, 16'd4, 16'($urandom), 16'($urandom), 16'd0);
        hold_armed = 1'b1;
        count = 24;
      end else if (k == 1) begin
        // The tallest glyph, replayed.
        set_all(16'd3, 16'd64, 16'($urandom), 16'($urandom), 16'd1);
        count = sb.bytes_to_glyph_end();
      end else begin
        if ($urandom_range(0, 1)) write_reg(CfgGlyphWidth, pick_value(CfgGlyphWidth));
        if ($urandom_range(0, 1)) write_reg(CfgGlyphHeight, pick_value(CfgGlyphHeight));
        if ($urandom_range(0, 1)) write_reg(CfgFgColor, pick_value(CfgFgColor));
        if ($urandom_range(0, 1)) write_reg(CfgBgColor, pick_value(CfgBgColor));
        if ($urandom_range(0, 1)) write_reg(CfgDoubleHt, pick_value(CfgDoubleHt));
        end_writes();
        glyph = sb.row_bytes() * sb.used_height();
        left  = sb.bytes_to_glyph_end();
        if ($urandom_range(0, 4) == 0) begin
          count = $urandom_range(1, 12);
        end else begin
          count = left + $urandom_range(0, 2) * glyph;
          if (count > 60) count = (left <= 60) ? left : $urandom_range(1, 12);
        end
      end
      send_random(count);
      random_sent += count;
      settle();
      k++;
    end

    $display("Covered %0d bytes in %0d phases: %0d pixels, %0d replayed, %0d glyphs closed.",
             bytes_sent, phases_run, sb.pixels_checked, sb.repeats_checked, sb.glyphs_closed);
    $display("Input stalls on a full queue: %0d cycles; %0d mismatches, %0d pixels left over.",
             full_stalls, sb.errors, sb.pixels_due.size());
    if (sb.errors == 0 && sb.pixels_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #4000000;
    $display("Run timed out with %0d pixels outstanding.", sb.pixels_due.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/gbps_pkg.sv
rtl/gbps_ram.sv
rtl/gbps_fifo.sv
rtl/gbps_front.sv
rtl/gbps_back.sv
rtl/glyph_bitmap_to_pixel_stream_unit.sv
rtl/gbps_checker.sv
tb/glyph_bitmap_to_pixel_stream_unit_tb.sv
